@@ src/tcbq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the two-channel bandpass biquad.
// Coefficient register widths, register indexes and the coefficient bundle.
// No dependencies.
package tcbq_pkg;

	localparam int GAIN_W     = 24;
	localparam int COEF1_W    = 26;
	localparam int COEF2_W    = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEED_GAIN   = 2'd0,
		REG_FEEDBACK_1  = 2'd1,
		REG_FEEDBACK_2  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic        [GAIN_W-1:0]  gain;
		logic signed [COEF1_W-1:0] a1;
		logic signed [COEF2_W-1:0] a2;
	} coef_t;

endpackage
`default_nettype wire

@@ src/tcbq_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Input sample channel: valid/ready with channel tag and sample.
// No dependencies.
interface tcbq_in_if #(
	parameter int CHAN_W = 1,
	parameter int DATA_W = 24
);
	logic                     valid;
	logic                     ready;
	logic        [CHAN_W-1:0] chan;
	logic signed [DATA_W-1:0] sample_in;

	modport source(output valid, output chan, output sample_in, input ready);
	modport sink(input valid, input chan, input sample_in, output ready);
endinterface
`default_nettype wire

@@ src/tcbq_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Filtered sample channel: valid/ready with channel tag and sample.
// No dependencies.
interface tcbq_out_if #(
	parameter int CHAN_W = 1,
	parameter int DATA_W = 24
);
	logic                     valid;
	logic                     ready;
	logic        [CHAN_W-1:0] chan_out;
	logic signed [DATA_W-1:0] sample_out;

	modport source(output valid, output chan_out, output sample_out, input ready);
	modport sink(input valid, input chan_out, input sample_out, output ready);
endinterface
`default_nettype wire

@@ src/tcbq_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Coefficient write channel: valid/ready with register index and data.
// Depends on tcbq_pkg for the index and data widths.
interface tcbq_cfg_if;
	import tcbq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/tcbq_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Coefficient register file: decodes writes into gain, a1 and a2.
// Depends on tcbq_pkg and tcbq_cfg_if.
module tcbq_cfg (
	input  wire               clk,
	input  wire               arst_n,
	tcbq_cfg_if.sink          cfg,
	output tcbq_pkg::coef_t   coef
);
	import tcbq_pkg::*;

	coef_t coef_q;

	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			// unknown indexes drop the write
			unique case (reg_idx_t'(cfg.index))
				REG_FEED_GAIN:  coef_q.gain <= cfg.data[GAIN_W-1:0];
				REG_FEEDBACK_1: coef_q.a1   <= cfg.data[COEF1_W-1:0];
				REG_FEEDBACK_2: coef_q.a2   <= cfg.data[COEF2_W-1:0];
				default:        coef_q      <= coef_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/tcbq_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Biquad product sum: g*(x - x2) - a1*y1 - a2*y2, rounded and saturated.
// Depends on tcbq_pkg for the coefficient bundle.
module tcbq_mac #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 24
) (
	input  wire signed [SAMPLE_BITS-1:0] x,
	input  wire signed [SAMPLE_BITS-1:0] x2,
	input  wire signed [SAMPLE_BITS-1:0] y1,
	input  wire signed [SAMPLE_BITS-1:0] y2,
	input  wire tcbq_pkg::coef_t         coef,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import tcbq_pkg::*;

	localparam int P0_W  = SAMPLE_BITS + GAIN_W + 2;
	localparam int P1_W  = SAMPLE_BITS + COEF1_W;
	localparam int P2_W  = SAMPLE_BITS + COEF2_W;
	localparam int HEAD  = (COEF_FRAC_BITS + 2 > 28) ? COEF_FRAC_BITS + 2 : 28;
	localparam int ACC_W = SAMPLE_BITS + HEAD;
	localparam int TOP   = COEF_FRAC_BITS + SAMPLE_BITS - 1;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [GAIN_W:0]        gain_s;
	logic signed [P0_W-1:0]        p0;
	logic signed [P1_W-1:0]        p1;
	logic signed [P2_W-1:0]        p2;
	logic signed [ACC_W-1:0]       acc;
	logic        [ACC_W-1-TOP:0]   head;

	always_comb begin
		diff   = {x[SAMPLE_BITS-1], x} - {x2[SAMPLE_BITS-1], x2};
		gain_s = {1'b0, coef.gain};
		p0     = diff * gain_s;
		p1     = coef.a1 * y1;
		p2     = coef.a2 * y2;
		acc    = ACC_W'(p0) - ACC_W'(p1) - ACC_W'(p2) + RND;
		// the sample's sign bit and all bits above it must match the sign to fit
		head   = acc[ACC_W-1:TOP];
		if (!acc[ACC_W-1] && (|head)) begin
			y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (acc[ACC_W-1] && !(&head)) begin
			y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y = acc[TOP:COEF_FRAC_BITS];
		end
	end

endmodule
`default_nettype wire

@@ src/two_channel_bandpass_biquad.sv @@
`timescale 1ns / 1ps
// Two-channel Direct Form I bandpass biquad with per-channel state.
// Path: input register, combinational product sum, then the result register.
// Throughput: 1 sample per cycle while out_ch is ready, any channel order; the combinational
// product sum between input and result registers closes the y1 recurrence.
// Reset: async active low clears coefficients, channel state and valids.
`default_nettype none
module two_channel_bandpass_biquad #(
	parameter int CHANNELS       = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	tcbq_in_if.sink     in_ch,
	tcbq_out_if.source  out_ch,
	tcbq_cfg_if.sink    cfg
);
	import tcbq_pkg::*;

	localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	coef_t coef;

	logic                          v_s1;
	logic        [CHAN_W-1:0]      chan_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;

	logic                          ovalid_q;
	logic        [CHAN_W-1:0]      ochan_q;
	logic signed [SAMPLE_BITS-1:0] osample_q;

	logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] y1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] y2_q [CHANNELS];

	logic                          advance;
	logic                          commit;
	logic                          in_range;
	logic signed [SAMPLE_BITS-1:0] x2_rd;
	logic signed [SAMPLE_BITS-1:0] y1_rd;
	logic signed [SAMPLE_BITS-1:0] y2_rd;
	logic signed [SAMPLE_BITS-1:0] y_new;

	tcbq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	assign advance     = !ovalid_q || out_ch.ready;
	assign commit      = v_s1 && advance;
	assign in_ch.ready = !v_s1 || advance;
	assign in_range    = {1'b0, chan_s1} < (CHAN_W + 1)'(CHANNELS);

	always_comb begin
		x2_rd = '0;
		y1_rd = '0;
		y2_rd = '0;
		if (in_range) begin
			x2_rd = x2_q[chan_s1];
			y1_rd = y1_q[chan_s1];
			y2_rd = y2_q[chan_s1];
		end
	end

	tcbq_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.x    (x_s1),
		.x2   (x2_rd),
		.y1   (y1_rd),
		.y2   (y2_rd),
		.coef (coef),
		.y    (y_new)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			chan_s1 <= in_ch.chan;
			x_s1    <= in_ch.sample_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ochan_q   <= chan_s1;
			osample_q <= in_range ? y_new : '0;
		end
	end

	// channel state advances as the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				x1_q[c] <= '0;
				x2_q[c] <= '0;
				y1_q[c] <= '0;
				y2_q[c] <= '0;
			end
		end else if (commit && in_range) begin
			x2_q[chan_s1] <= x1_q[chan_s1];
			x1_q[chan_s1] <= x_s1;
			y2_q[chan_s1] <= y1_q[chan_s1];
			y1_q[chan_s1] <= y_new;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.chan_out   = ochan_q;
	assign out_ch.sample_out = osample_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (v_s1 && ovalid_q && !out_ch.ready))
		else $error("input stalled while a stage is free");

	a_y1_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && in_range) |=> (y1_q[ochan_q] == osample_q))
		else $error("stored y1 differs from delivered sample");

	a_x1_tracks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && in_range) |=> (x1_q[ochan_q] == $past(x_s1)))
		else $error("stored x1 differs from filtered input");

	a_bad_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !in_range) |=> (osample_q == '0))
		else $error("out-of-range channel produced nonzero sample");

	a_result_follows_stage: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> ovalid_q)
		else $error("committed sample did not reach the result register");

endmodule
`default_nettype wire

@@ bench/two_channel_bandpass_biquad_test.sv @@
`timescale 1ns / 1ps
// Testbench for two_channel_bandpass_biquad: random and directed samples on both channels.
// Coefficients are loaded between bursts, and every filtered sample is checked against a predictor.
// Depends on tcbq_pkg, the three channel interfaces and the block itself.
module two_channel_bandpass_biquad_test;
	import tcbq_pkg::*;

	localparam int SAMPLE_W    = 24;
	localparam int NUM_CHAN    = 2;
	localparam int FRAC_W      = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BURSTS      = 10;
	localparam int BURST_LEN   = 125;
	// no register lives at this index; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint ROUND_HALF = longint'(1) << (FRAC_W - 1);
	localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef struct {
		logic                       ch;
		logic signed [SAMPLE_W-1:0] sample;
	} filtered_t;

	class filter_scoreboard;
		logic        [GAIN_W-1:0]   gain;
		logic signed [COEF1_W-1:0]  a1;
		logic signed [COEF2_W-1:0]  a2;
		logic signed [SAMPLE_W-1:0] in_d1 [NUM_CHAN];
		logic signed [SAMPLE_W-1:0] in_d2 [NUM_CHAN];
		logic signed [SAMPLE_W-1:0] out_d1 [NUM_CHAN];
		logic signed [SAMPLE_W-1:0] out_d2 [NUM_CHAN];
		filtered_t pending [$];
		int mismatches;

		function new();
			gain = '0;
			a1 = '0;
			a2 = '0;
			foreach (in_d1[c]) begin
				in_d1[c] = '0;
				in_d2[c] = '0;
				out_d1[c] = '0;
				out_d2[c] = '0;
			end
			mismatches = 0;
		endfunction

		function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_FEED_GAIN: gain = value[GAIN_W-1:0];
				REG_FEEDBACK_1: a1 = value[COEF1_W-1:0];
				REG_FEEDBACK_2: a2 = value[COEF2_W-1:0];
				default: ;
			endcase
		endfunction

		// Direct Form I step: round half up, then clamp to the sample range
		function void note_sample(logic ch, logic signed [SAMPLE_W-1:0] x);
			longint acc;
			longint y;
			acc = longint'(gain) * (longint'(x) - longint'(in_d2[ch]))
				- longint'(a1) * longint'(out_d1[ch])
				- longint'(a2) * longint'(out_d2[ch]);
			y = (acc + ROUND_HALF) >>> FRAC_W;
			if (y > SAMPLE_MAX)
				y = SAMPLE_MAX;
			else if (y < SAMPLE_MIN)
				y = SAMPLE_MIN;
			in_d2[ch] = in_d1[ch];
			in_d1[ch] = x;
			out_d2[ch] = out_d1[ch];
			out_d1[ch] = y[SAMPLE_W-1:0];
			pending.push_back('{ch, y[SAMPLE_W-1:0]});
		endfunction

		function void check_filtered(logic ch, logic signed [SAMPLE_W-1:0] y);
			filtered_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, chan_out %0d sample_out %0d", $time, ch, y);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: chan_out mismatch, expected %0d actual %0d", $time, want.ch, ch);
				mismatches++;
			end
			if (y !== want.sample) begin
				$display("%0t: sample_out mismatch, expected %0d actual %0d",
					$time, want.sample, y);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int in_idle_pct = 6;
	int out_idle_pct = 6;
	filter_scoreboard sb = new();

	tcbq_in_if  in_bus ();
	tcbq_out_if out_bus ();
	tcbq_cfg_if cfg_bus ();

	two_channel_bandpass_biquad dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg(cfg_bus)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
			sb.check_filtered(out_bus.chan_out, out_bus.sample_out);
	end

	task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] x);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.chan <= ch;
		in_bus.sample_in <= x;
		do @(posedge clk); while (in_bus.ready !== 1'b1);
		sb.note_sample(ch, x);
	endtask

	// drop valid and hold until every filtered sample has come back
	task automatic quiesce();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.note_write(idx, value);
	endtask

	task automatic load_coefs(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] c1,
			input logic [CFG_DATA_W-1:0] c2);
		quiesce();
		write_reg(REG_FEED_GAIN, g);
		write_reg(REG_FEEDBACK_1, c1);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		write_reg(REG_FEEDBACK_2, c2);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] s;
		case ($urandom_range(9))
			0: s = 24'sh7FFFFF;
			1: s = 24'sh800000;
			2, 3: begin
				s = SAMPLE_W'($urandom_range(2000));
				s = s - 24'sd1000;
			end
			default: s = SAMPLE_W'($urandom);
		endcase
		return s;
	endfunction

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** two_channel_bandpass_biquad: FAILED **");
		$finish;
	end

	initial begin
		int ph;
		int n;
		real w;
		real alpha;
		real a0;
		logic [CFG_DATA_W-1:0] g;
		logic [CFG_DATA_W-1:0] c1;
		logic [CFG_DATA_W-1:0] c2;

		clk = 1'b0;
		arst_n = 1'b0;
		in_bus.valid = 1'b0;
		in_bus.chan = '0;
		in_bus.sample_in = '0;
		out_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients are zero: output must be zero
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);

		// full-scale gain, upper data bits set: drive both saturation rails
		load_coefs(26'h3FFFFFF, 26'h0, 26'h0);
		send_sample(1'b0, 24'sh800000);
		send_sample(1'b0, 24'sh000000);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b0, 24'sh800000);
		send_sample(1'b0, 24'sh800000);
		send_sample(1'b1, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh000001);

		// gain of one half: odd differences land exactly on rounding ties
		load_coefs(26'h0800000, 26'h0, 26'h0);
		send_sample(1'b1, 24'sh000000);
		send_sample(1'b1, 24'sh000000);
		send_sample(1'b1, 24'sh000001);
		send_sample(1'b1, 24'shFFFFFF);

		// feedback extremes
		load_coefs(26'h0, 26'h2000000, 26'h0FFFFFF);
		send_sample(1'b0, 24'sh000000);
		send_sample(1'b1, 24'sh000000);
		send_sample(1'b0, 24'sh000000);
		send_sample(1'b1, 24'sh000000);
		load_coefs(26'h1000000, 26'h1FFFFFF, 26'h1000000);
		send_sample(1'b0, 24'sh7FFFFF);
		send_sample(1'b1, 24'sh800000);
		send_sample(1'b0, 24'sh123456);
		send_sample(1'b1, 24'shFEDCBA);

		for (ph = 0; ph < BURSTS; ph++) begin
			case (ph % 3)
				0: begin
					// stable bandpass sweep point
					w = 3.14159265 * $urandom_range(1, 999) / 1000.0;
					alpha = $urandom_range(1, 1000) / 1000.0;
					a0 = 1.0 + alpha;
					g = CFG_DATA_W'($rtoi(alpha / a0 * 16777216.0));
					c1 = CFG_DATA_W'($rtoi(-2.0 * $cos(w) / a0 * 16777216.0));
					c2 = CFG_DATA_W'($rtoi((1.0 - alpha) / a0 * 16777216.0));
				end
				1: begin
					g = CFG_DATA_W'($urandom);
					c1 = CFG_DATA_W'($urandom);
					c2 = CFG_DATA_W'($urandom);
				end
				default: begin
					case ($urandom_range(2))
						0: g = 26'h0;
						1: g = 26'h0FFFFFF;
						default: g = 26'h0800000;
					endcase
					case ($urandom_range(2))
						0: c1 = 26'h2000000;
						1: c1 = 26'h1FFFFFF;
						default: c1 = 26'h0;
					endcase
					case ($urandom_range(2))
						0: c2 = 26'h1000000;
						1: c2 = 26'h0FFFFFF;
						default: c2 = 26'h0;
					endcase
				end
			endcase
			load_coefs(g, c1, c2);
			in_idle_pct = (ph == 4) ? 0 : 6;
			out_idle_pct = (ph == 4) ? 0 : 6;
			for (n = 0; n < BURST_LEN; n++) begin
				if (ph == 7 && n == BURST_LEN / 2)
					quiesce();
				send_sample(1'($urandom_range(1)), pick_sample());
			end
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("** two_channel_bandpass_biquad: PASSED **");
		else
			$display("** two_channel_bandpass_biquad: FAILED **");
		$finish;
	end
endmodule

@@ two_channel_bandpass_biquad.f @@
src/tcbq_pkg.sv
src/tcbq_in_if.sv
src/tcbq_out_if.sv
src/tcbq_cfg_if.sv
src/tcbq_cfg.sv
src/tcbq_mac.sv
src/two_channel_bandpass_biquad.sv
bench/two_channel_bandpass_biquad_test.sv
